// ===== rtl/gct_pkg.sv =====
// ----------------------------------------------------------------------------
// Graph connectivity tracker package
// Shared sizing default and the request and result types of the tracker.
// ----------------------------------------------------------------------------
package gct_pkg;

    localparam int NODES_DEFAULT = 16;

    typedef struct packed {
        logic [63:0] source_key;
        logic [63:0] dest_key;
        logic [15:0] edge_cost;
    } request_t;

    typedef struct packed {
        logic [3:0] source_index;
        logic [3:0] dest_index;
        logic       all_connected;
        logic       table_full;
        logic [4:0] nodes_in_use;
    } result_t;

endpackage

// ===== rtl/gct_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ===== rtl/graph_connectivity_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Graph connectivity tracker
// Registers 64-bit node keys, keeps an undirected link matrix and reports
// after every request whether all nodes in use are reachable from node 0.
// ----------------------------------------------------------------------------
// Each request is handled on its own while request_stall is high. The key
// table is scanned one entry per cycle through its RAM port. Unless the
// table would overflow, new keys are written to the next free entries and
// the two affected matrix rows are updated by read-modify-write, source row
// first. The reachability sweep reads one matrix row per cycle through the
// RAM port while reached nodes wait to be expanded. A row read is merged in
// the cycle after it is issued, so along a chain each node waits for the row
// before it. The finished result waits in an output register, so the next
// request can be taken while it waits; while the register still holds a
// stalled result, the tracker stays in its done state.
module graph_connectivity_tracker_top
    import gct_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     request_valid,
    output logic     request_stall,
    input  request_t request,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result
);

    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SEARCH  = 4'd1;
    localparam logic [3:0] S_ALLOC   = 4'd2;
    localparam logic [3:0] S_ALLOC_D = 4'd3;
    localparam logic [3:0] S_E_RD_S  = 4'd4;
    localparam logic [3:0] S_E_WR_S  = 4'd5;
    localparam logic [3:0] S_E_RD_D  = 4'd6;
    localparam logic [3:0] S_E_WR_D  = 4'd7;
    localparam logic [3:0] S_SW_INIT = 4'd8;
    localparam logic [3:0] S_SW_RUN  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [63:0]      skey_reg, skey_next;
    logic [63:0]      dkey_reg, dkey_next;
    logic             cost_nz_reg, cost_nz_next;
    logic [CW-1:0]    tot_reg, tot_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IW-1:0]    rd_idx_reg, rd_idx_next;
    logic             s_found_reg, s_found_next;
    logic             d_found_reg, d_found_next;
    logic [IW-1:0]    si_reg, si_next;
    logic [IW-1:0]    di_reg, di_next;
    logic             full_reg, full_next;
    logic             conn_reg, conn_next;
    logic [NODES-1:0] seen_reg, seen_next;
    logic [NODES-1:0] expanded_reg, expanded_next;
    logic [NODES-1:0] row_valid_reg, row_valid_next;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg, result_next;

    logic             key_wr_en;
    logic [IW-1:0]    key_wr_addr;
    logic [63:0]      key_wr_data;
    logic [IW-1:0]    key_rd_addr;
    logic [63:0]      key_rd_data;

    logic             adj_wr_en;
    logic [IW-1:0]    adj_wr_addr;
    logic [NODES-1:0] adj_wr_data;
    logic [IW-1:0]    adj_rd_addr;
    logic [NODES-1:0] adj_rd_data;

    logic [NODES-1:0] in_use;
    logic [NODES-1:0] pend;
    logic [IW-1:0]    pend_idx;
    logic [NODES-1:0] row_s;
    logic [NODES-1:0] row_d;
    logic [NODES-1:0] bit_s;
    logic [NODES-1:0] bit_d;
    logic [NODES-1:0] swept_row;
    logic             s_new;
    logic             d_new;
    logic             same_key;
    logic [CW:0]      need_total;
    logic [IW+3:0]    si_wide;
    logic [IW+3:0]    di_wide;
    logic [CW+4:0]    tot_wide;

    gct_ram #(
        .WIDTH (64),
        .DEPTH (NODES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_wr_data),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    gct_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_adj_ram (
        .clk     (clk),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_addr (adj_rd_addr),
        .rd_data (adj_rd_data)
    );

    always_comb
    begin
        for (int k = 0; k < NODES; k++)
        begin
            in_use[k] = (CW'(k) < tot_reg);
        end
        pend     = seen_reg & ~expanded_reg & in_use;
        pend_idx = '0;
        for (int k = NODES - 1; k >= 0; k--)
        begin
            if (pend[k])
            begin
                pend_idx = IW'(k);
            end
        end
    end

    assign bit_s     = {{(NODES-1){1'b0}}, 1'b1} << si_reg;
    assign bit_d     = {{(NODES-1){1'b0}}, 1'b1} << di_reg;
    assign row_s     = row_valid_reg[si_reg] ? adj_rd_data : '0;
    assign row_d     = row_valid_reg[di_reg] ? adj_rd_data : '0;
    assign swept_row = row_valid_reg[rd_idx_reg] ? adj_rd_data : '0;

    assign same_key   = (skey_reg == dkey_reg);
    assign s_new      = !s_found_reg;
    assign d_new      = !d_found_reg && !(s_new && same_key);
    assign need_total = (CW+1)'(tot_reg) + (CW+1)'(s_new) + (CW+1)'(d_new);

    assign si_wide  = (IW+4)'(si_reg);
    assign di_wide  = (IW+4)'(di_reg);
    assign tot_wide = (CW+5)'(tot_reg);

    always_comb
    begin
        state_next        = state_reg;
        skey_next         = skey_reg;
        dkey_next         = dkey_reg;
        cost_nz_next      = cost_nz_reg;
        tot_next          = tot_reg;
        ptr_next          = ptr_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = rd_idx_reg;
        s_found_next      = s_found_reg;
        d_found_next      = d_found_reg;
        si_next           = si_reg;
        di_next           = di_reg;
        full_next         = full_reg;
        conn_next         = conn_reg;
        seen_next         = seen_reg;
        expanded_next     = expanded_reg;
        row_valid_next    = row_valid_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        key_wr_en   = 1'b0;
        key_wr_addr = tot_reg[IW-1:0];
        key_wr_data = skey_reg;
        key_rd_addr = ptr_reg[IW-1:0];
        adj_wr_en   = 1'b0;
        adj_wr_addr = si_reg;
        adj_wr_data = '0;
        adj_rd_addr = si_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (request_valid)
                begin
                    skey_next    = request.source_key;
                    dkey_next    = request.dest_key;
                    cost_nz_next = (request.edge_cost != 16'd0);
                    s_found_next = 1'b0;
                    d_found_next = 1'b0;
                    si_next      = '0;
                    di_next      = '0;
                    full_next    = 1'b0;
                    ptr_next     = '0;
                    state_next   = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (ptr_reg != tot_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[IW-1:0];
                    ptr_next    = ptr_reg + CW'(1);
                end
                if (rd_vld_reg)
                begin
                    if (!s_found_reg && key_rd_data == skey_reg)
                    begin
                        s_found_next = 1'b1;
                        si_next      = rd_idx_reg;
                    end
                    if (!d_found_reg && key_rd_data == dkey_reg)
                    begin
                        d_found_next = 1'b1;
                        di_next      = rd_idx_reg;
                    end
                end
                if (ptr_reg == tot_reg && !rd_vld_reg)
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (need_total > (CW+1)'(NODES))
                begin
                    full_next  = 1'b1;
                    si_next    = '0;
                    di_next    = '0;
                    state_next = S_SW_INIT;
                end
                else
                begin
                    if (s_new)
                    begin
                        key_wr_en = 1'b1;
                        si_next   = tot_reg[IW-1:0];
                        tot_next  = tot_reg + CW'(1);
                        if (same_key)
                        begin
                            di_next = tot_reg[IW-1:0];
                        end
                    end
                    state_next = d_new ? S_ALLOC_D : S_E_RD_S;
                end
            end
            S_ALLOC_D:
            begin
                key_wr_en   = 1'b1;
                key_wr_data = dkey_reg;
                di_next     = tot_reg[IW-1:0];
                tot_next    = tot_reg + CW'(1);
                state_next  = S_E_RD_S;
            end
            S_E_RD_S:
            begin
                adj_rd_addr = si_reg;
                state_next  = S_E_WR_S;
            end
            S_E_WR_S:
            begin
                adj_wr_en              = 1'b1;
                adj_wr_addr            = si_reg;
                adj_wr_data            = cost_nz_reg ? (row_s | bit_d) : (row_s & ~bit_d);
                row_valid_next[si_reg] = 1'b1;
                state_next             = S_E_RD_D;
            end
            S_E_RD_D:
            begin
                adj_rd_addr = di_reg;
                state_next  = S_E_WR_D;
            end
            S_E_WR_D:
            begin
                adj_wr_en              = 1'b1;
                adj_wr_addr            = di_reg;
                adj_wr_data            = cost_nz_reg ? (row_d | bit_s) : (row_d & ~bit_s);
                row_valid_next[di_reg] = 1'b1;
                state_next             = S_SW_INIT;
            end
            S_SW_INIT:
            begin
                expanded_next = '0;
                if (tot_reg == '0)
                begin
                    seen_next  = '0;
                    conn_next  = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    seen_next  = {{(NODES-1){1'b0}}, 1'b1};
                    state_next = S_SW_RUN;
                end
            end
            S_SW_RUN:
            begin
                if (rd_vld_reg)
                begin
                    seen_next = (seen_reg | swept_row) & in_use;
                end
                if (pend != '0)
                begin
                    adj_rd_addr             = pend_idx;
                    rd_vld_next             = 1'b1;
                    rd_idx_next             = pend_idx;
                    expanded_next[pend_idx] = 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    conn_next  = (seen_reg == in_use);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.source_index  = si_wide[3:0];
                    result_next.dest_index    = di_wide[3:0];
                    result_next.all_connected = conn_reg;
                    result_next.table_full    = full_reg;
                    result_next.nodes_in_use  = tot_wide[4:0];
                    result_valid_next         = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tot_reg          <= '0;
            ptr_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            row_valid_reg    <= '0;
            seen_reg         <= '0;
            expanded_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tot_reg          <= tot_next;
            ptr_reg          <= ptr_next;
            rd_vld_reg       <= rd_vld_next;
            row_valid_reg    <= row_valid_next;
            seen_reg         <= seen_next;
            expanded_reg     <= expanded_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skey_reg    <= skey_next;
        dkey_reg    <= dkey_next;
        cost_nz_reg <= cost_nz_next;
        rd_idx_reg  <= rd_idx_next;
        s_found_reg <= s_found_next;
        d_found_reg <= d_found_next;
        si_reg      <= si_next;
        di_reg      <= di_next;
        full_reg    <= full_next;
        conn_reg    <= conn_next;
        result_reg  <= result_next;
    end

    assign request_stall = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

endmodule

// ===== verif/graph_connectivity_tracker_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Graph connectivity tracker testbench
// Sends link requests through the valid and stall handshake while both sides
// pause at random. Every result is checked field by field, six directed ones
// against fixed values, the rest against a local model of the key table, link
// matrix and reachability sweep. Directed requests come first, then 1200
// random requests alternating between building links and cutting one node off.
// ----------------------------------------------------------------------------
module graph_connectivity_tracker_top_test;
    import gct_pkg::*;

    localparam int NODES = NODES_DEFAULT;
    localparam int RANDOM_REQUESTS = 1200;
    localparam int PHASE_LENGTH = 120;
    localparam int HOLD_POINT = 600;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [63:0] KEY_LOW = 64'h0000_0000_0000_0000;
    localparam logic [63:0] KEY_HIGH = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEY_SELF = 64'h8000_0000_0000_0001;

    typedef struct {
        request_t req;
        bit       typed;
        result_t  want;
    } plan_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     request_valid = 1'b0;
    logic     request_stall;
    request_t request = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    result_t  result;

    logic [63:0]      node_key [NODES];
    logic [NODES-1:0] link_row [NODES];
    int               node_count = 0;
    result_t          pending_results [$];
    plan_row_t        plan_rows [$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               sent_count = 0;

    graph_connectivity_tracker_top #(
        .NODES(NODES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .request_valid(request_valid),
        .request_stall(request_stall),
        .request(request),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("graph_connectivity_tracker_top_test failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int find_node(input logic [63:0] key);
        for (int i = 0; i < node_count; i++)
        begin
            if (node_key[i] == key)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic result_t apply_link_request(input request_t r);
        int               s;
        int               d;
        int               needed;
        result_t          res;
        logic [NODES-1:0] used;
        logic [NODES-1:0] seen;
        logic [NODES-1:0] prev;
        s = find_node(r.source_key);
        d = find_node(r.dest_key);
        needed = 0;
        res = '0;
        if (s < 0)
        begin
            needed++;
        end
        if (d < 0 && !(s < 0 && r.source_key == r.dest_key))
        begin
            needed++;
        end
        if (node_count + needed > NODES)
        begin
            res.table_full = 1'b1;
        end
        else
        begin
            if (s < 0)
            begin
                node_key[node_count] = r.source_key;
                s = node_count;
                node_count++;
            end
            if (d < 0)
            begin
                d = find_node(r.dest_key);
                if (d < 0)
                begin
                    node_key[node_count] = r.dest_key;
                    d = node_count;
                    node_count++;
                end
            end
            res.source_index = 4'(s);
            res.dest_index = 4'(d);
            link_row[s][d] = (r.edge_cost != 16'h0000);
            link_row[d][s] = (r.edge_cost != 16'h0000);
        end
        used = '0;
        for (int i = 0; i < node_count; i++)
        begin
            used[i] = 1'b1;
        end
        seen = '0;
        if (node_count > 0)
        begin
            seen[0] = 1'b1;
            prev = '0;
            while (seen != prev)
            begin
                prev = seen;
                for (int i = 0; i < node_count; i++)
                begin
                    if (seen[i])
                    begin
                        seen = seen | link_row[i];
                    end
                end
                seen = seen & used;
            end
        end
        res.all_connected = (node_count > 0) && (seen == used);
        res.nodes_in_use = 5'(node_count);
        return res;
    endfunction

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            report_error($sformatf("result %h with no request pending", got));
            return;
        end
        want = pending_results.pop_front();
        if (got.source_index != want.source_index)
        begin
            report_error($sformatf("source_index %0d, want %0d",
                                   got.source_index, want.source_index));
        end
        if (got.dest_index != want.dest_index)
        begin
            report_error($sformatf("dest_index %0d, want %0d",
                                   got.dest_index, want.dest_index));
        end
        if (got.all_connected != want.all_connected)
        begin
            report_error($sformatf("all_connected %0d, want %0d",
                                   got.all_connected, want.all_connected));
        end
        if (got.table_full != want.table_full)
        begin
            report_error($sformatf("table_full %0d, want %0d",
                                   got.table_full, want.table_full));
        end
        if (got.nodes_in_use != want.nodes_in_use)
        begin
            report_error($sformatf("nodes_in_use %0d, want %0d",
                                   got.nodes_in_use, want.nodes_in_use));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            check_result(result);
        end
    end

    function automatic int pick_gap(input int n);
        int r;
        r = $urandom_range(0, 99);
        if ((n / 50) % 5 == 2)
        begin
            return 0;
        end
        if (r < 45)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic send_request(input request_t r, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = pick_gap(sent_count);
        if (gap > 0)
        begin
            @(negedge clk);
            request_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        request <= r;
        request_valid <= 1'b1;
        @(posedge clk);
        while (request_stall)
        begin
            @(posedge clk);
        end
        predicted = apply_link_request(r);
        pending_results.push_back(typed ? want : predicted);
        sent_count++;
    endtask

    function automatic void add_row(input request_t r, input bit typed, input result_t want);
        plan_row_t row;
        row.req = r;
        row.typed = typed;
        row.want = want;
        plan_rows.push_back(row);
    endfunction

    function automatic logic [63:0] chain_key(input int n);
        return 64'h9E37_79B9_7F4A_7C15 * n;
    endfunction

    initial
    begin
        int mode;
        int len;
        forever
        begin
            mode = $urandom_range(0, 9);
            @(negedge clk);
            if (mode < 4)
            begin
                result_stall <= 1'b0;
                len = $urandom_range(1, 8);
            end
            else if (mode < 7)
            begin
                result_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end
            else if (mode < 9)
            begin
                result_stall <= 1'b0;
                len = $urandom_range(20, 80);
            end
            else
            begin
                result_stall <= 1'b1;
                len = $urandom_range(10, 30);
            end
            repeat (len - 1) @(negedge clk);
        end
    end

    initial
    begin
        request_t r;
        int       focus;
        int       pick;
        int       s;
        int       d;
        bit       cut_phase;
        focus = 0;
        for (int i = 0; i < NODES; i++)
        begin
            link_row[i] = '0;
            node_key[i] = '0;
        end

        add_row({KEY_LOW, KEY_HIGH, 16'hFFFF}, 1'b1, {4'd0, 4'd1, 1'b1, 1'b0, 5'd2});
        add_row({KEY_HIGH, KEY_LOW, 16'h0000}, 1'b1, {4'd1, 4'd0, 1'b0, 1'b0, 5'd2});
        add_row({KEY_SELF, KEY_SELF, 16'h0001}, 1'b1, {4'd2, 4'd2, 1'b0, 1'b0, 5'd3});
        add_row({KEY_HIGH, KEY_LOW, 16'h0001}, 1'b1, {4'd1, 4'd0, 1'b0, 1'b0, 5'd3});
        add_row({KEY_LOW, KEY_SELF, 16'h8000}, 1'b1, {4'd0, 4'd2, 1'b1, 1'b0, 5'd3});
        add_row({KEY_SELF, chain_key(3), 16'h7FFF}, 1'b1, {4'd2, 4'd3, 1'b1, 1'b0, 5'd4});
        add_row({chain_key(4), chain_key(5), 16'h1234}, 1'b0, '0);
        add_row({chain_key(6), chain_key(7), 16'h0000}, 1'b0, '0);
        add_row({chain_key(8), chain_key(9), 16'hA5A5}, 1'b0, '0);
        add_row({chain_key(10), chain_key(11), 16'h0001}, 1'b0, '0);
        add_row({chain_key(12), chain_key(13), 16'hFFFF}, 1'b0, '0);
        add_row({chain_key(14), KEY_HIGH, 16'h5555}, 1'b0, '0);
        add_row({chain_key(15), chain_key(16), 16'h0001}, 1'b0, '0);
        add_row({chain_key(17), chain_key(17), 16'h00FF}, 1'b0, '0);
        add_row({KEY_LOW, chain_key(18), 16'h0001}, 1'b0, '0);
        add_row({chain_key(19), chain_key(19), 16'h0001}, 1'b0, '0);
        add_row({chain_key(17), KEY_LOW, 16'hFFFF}, 1'b0, '0);
        add_row({KEY_LOW, KEY_LOW, 16'h0000}, 1'b0, '0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan_rows[k])
        begin
            send_request(plan_rows[k].req, plan_rows[k].typed, plan_rows[k].want);
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            cut_phase = ((n / PHASE_LENGTH) % 2) == 1;
            if (n % PHASE_LENGTH == 0)
            begin
                focus = $urandom_range(0, node_count - 1);
            end
            pick = $urandom_range(0, 99);
            s = $urandom_range(0, node_count - 1);
            d = $urandom_range(0, node_count - 1);
            r.source_key = node_key[s];
            r.dest_key = node_key[d];
            if ($urandom_range(0, 99) < (cut_phase ? 20 : 75))
            begin
                r.edge_cost = 16'($urandom_range(1, 65535));
            end
            else
            begin
                r.edge_cost = 16'h0000;
            end
            if (cut_phase && pick < 80)
            begin
                r.source_key = node_key[focus];
                r.edge_cost = 16'h0000;
            end
            else if (pick < 6)
            begin
                r.source_key = {$urandom, $urandom};
            end
            else if (pick < 10)
            begin
                r.dest_key = node_key[d] ^ (64'd1 << $urandom_range(0, 63));
            end
            else if (pick < 12)
            begin
                r.source_key = {$urandom, $urandom};
                r.dest_key = r.source_key;
            end
            send_request(r, 1'b0, '0);
            if (n == HOLD_POINT)
            begin
                @(negedge clk);
                request_valid <= 1'b0;
                while (pending_results.size() != 0)
                begin
                    @(posedge clk);
                end
            end
        end

        @(negedge clk);
        request_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("graph_connectivity_tracker_top_test passed");
        end
        else
        begin
            $display("graph_connectivity_tracker_top_test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gct_pkg.sv
rtl/gct_ram.sv
rtl/graph_connectivity_tracker_top.sv
verif/graph_connectivity_tracker_top_test.sv
